>>> hw/rtl/trs_pkg.sv
// types and constants shared by the transform-to-matrix pipeline
package trs_pkg;

  localparam int unsigned FracShift = 28;
  localparam int unsigned TermW     = 34;  // Q6.28 holds every rotation term
  localparam int unsigned MulW      = 38;  // Q22.16 product after the shift back to 16 fraction bits
  localparam int unsigned NumTerms  = 9;
  localparam int unsigned NumAxes   = 3;

  localparam logic signed [TermW-1:0] OneQ28 = TermW'(1) << FracShift;
  localparam logic [31:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } trs_in_t;

  typedef struct packed {
    logic signed [31:0] row0_col0;
    logic signed [31:0] row0_col1;
    logic signed [31:0] row0_col2;
    logic signed [31:0] row1_col0;
    logic signed [31:0] row1_col1;
    logic signed [31:0] row1_col2;
    logic signed [31:0] row2_col0;
    logic signed [31:0] row2_col1;
    logic signed [31:0] row2_col2;
    logic signed [31:0] row3_col0;
    logic signed [31:0] row3_col1;
    logic signed [31:0] row3_col2;
  } trs_out_t;

  // quaternion products, Q4.28
  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] xy;
    logic signed [31:0] xz;
    logic signed [31:0] yz;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic [NumAxes-1:0][31:0] scale;
    logic [NumAxes-1:0][31:0] trans;
  } trs_prod_t;

  typedef struct packed {
    logic [NumTerms-1:0][TermW-1:0] term;
    logic [NumAxes-1:0][31:0]       scale;
    logic [NumAxes-1:0][31:0]       trans;
  } trs_term_t;

  typedef struct packed {
    logic [NumTerms-1:0][MulW-1:0] prod;
    logic [NumAxes-1:0][31:0]      trans;
  } trs_mul_t;

endpackage

>>> hw/rtl/trs_stream_if.sv
// valid/ready stream channel carrying one payload struct
interface trs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/trs_prod_stage.sv
// stage 1: the nine quaternion component products
module trs_prod_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  trs_pkg::trs_in_t   data_i,
  output logic               ready_o,
  output logic               valid_o,
  output trs_pkg::trs_prod_t data_o,
  input  logic               ready_i
);
  import trs_pkg::*;

  logic      valid_q;
  trs_prod_t data_d, data_q;

  always_comb begin
    data_d.xx    = $signed(data_i.quat_x) * $signed(data_i.quat_x);
    data_d.yy    = $signed(data_i.quat_y) * $signed(data_i.quat_y);
    data_d.zz    = $signed(data_i.quat_z) * $signed(data_i.quat_z);
    data_d.xy    = $signed(data_i.quat_x) * $signed(data_i.quat_y);
    data_d.xz    = $signed(data_i.quat_x) * $signed(data_i.quat_z);
    data_d.yz    = $signed(data_i.quat_y) * $signed(data_i.quat_z);
    data_d.wx    = $signed(data_i.quat_w) * $signed(data_i.quat_x);
    data_d.wy    = $signed(data_i.quat_w) * $signed(data_i.quat_y);
    data_d.wz    = $signed(data_i.quat_w) * $signed(data_i.quat_z);
    data_d.scale = {data_i.scale_z, data_i.scale_y, data_i.scale_x};
    data_d.trans = {data_i.trans_z, data_i.trans_y, data_i.trans_x};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> hw/rtl/trs_term_stage.sv
// stage 2: rotation matrix terms from the products, Q6.28
module trs_term_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  trs_pkg::trs_prod_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  output trs_pkg::trs_term_t data_o,
  input  logic               ready_i
);
  import trs_pkg::*;

  function automatic logic signed [TermW-1:0] ext(input logic [31:0] v);
    ext = {{(TermW-32){v[31]}}, v};
  endfunction

  logic                    valid_q;
  trs_term_t               data_d, data_q;
  logic signed [TermW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

  assign xx = ext(data_i.xx);
  assign yy = ext(data_i.yy);
  assign zz = ext(data_i.zz);
  assign xy = ext(data_i.xy);
  assign xz = ext(data_i.xz);
  assign yz = ext(data_i.yz);
  assign wx = ext(data_i.wx);
  assign wy = ext(data_i.wy);
  assign wz = ext(data_i.wz);

  // row-major order, rows scaled by x, y, z in the next stage
  always_comb begin
    data_d.term[0] = OneQ28 - ((yy + zz) <<< 1);
    data_d.term[1] = (xy + wz) <<< 1;
    data_d.term[2] = (xz - wy) <<< 1;
    data_d.term[3] = (xy - wz) <<< 1;
    data_d.term[4] = OneQ28 - ((xx + zz) <<< 1);
    data_d.term[5] = (yz + wx) <<< 1;
    data_d.term[6] = (xz + wy) <<< 1;
    data_d.term[7] = (yz - wx) <<< 1;
    data_d.term[8] = OneQ28 - ((xx + yy) <<< 1);
    data_d.scale   = data_i.scale;
    data_d.trans   = data_i.trans;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> hw/rtl/trs_mul_stage.sv
// stage 3: each term times its row scale, floored to 16 fraction bits (Q22.16)
module trs_mul_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  trs_pkg::trs_term_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  output trs_pkg::trs_mul_t  data_o,
  input  logic               ready_i
);
  import trs_pkg::*;

  localparam int unsigned FullW = TermW + 32;

  logic                          valid_q;
  trs_mul_t                      data_q;
  logic [NumTerms-1:0][MulW-1:0] prod_d;

  for (genvar i = 0; i < NumTerms; i++) begin : g_lane
    logic signed [FullW-1:0] full;
    assign full = $signed(data_i.term[i]) * $signed(data_i.scale[i / NumAxes]);
    // dropping the low bits of a signed product is an arithmetic floor
    assign prod_d[i] = full[FullW-1:FracShift];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q.prod  <= prod_d;
      data_q.trans <= data_i.trans;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> hw/rtl/trs_sat_stage.sv
// stage 4: saturation to 32 bits and the output register
module trs_sat_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  trs_pkg::trs_mul_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output trs_pkg::trs_out_t data_o,
  input  logic              ready_i
);
  import trs_pkg::*;

  logic                        valid_q;
  trs_out_t                    data_d, data_q;
  logic [NumTerms-1:0][31:0]   sat;

  for (genvar i = 0; i < NumTerms; i++) begin : g_lane
    logic [MulW-1:0] p;
    logic            fits;
    assign p    = data_i.prod[i];
    // value fits when all bits above bit 31 copy the sign
    assign fits = (p[MulW-1:31] == '0) || (p[MulW-1:31] == '1);
    assign sat[i] = fits ? p[31:0] : (p[MulW-1] ? SatMin : SatMax);
  end

  always_comb begin
    data_d.row0_col0 = sat[0];
    data_d.row0_col1 = sat[1];
    data_d.row0_col2 = sat[2];
    data_d.row1_col0 = sat[3];
    data_d.row1_col1 = sat[4];
    data_d.row1_col2 = sat[5];
    data_d.row2_col0 = sat[6];
    data_d.row2_col1 = sat[7];
    data_d.row2_col2 = sat[8];
    data_d.row3_col0 = data_i.trans[0];
    data_d.row3_col1 = data_i.trans[1];
    data_d.row3_col2 = data_i.trans[2];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> hw/rtl/trs_affine_compose_unit.sv
// top level: scale, quaternion rotation and translation to an affine matrix
//
// in_i carries one transform per transaction: three Q16.16 scales, a Q2.14
// quaternion (w, x, y, z) and a Q16.16 translation. out_o carries the
// twelve matrix entries: rows 0..2 are the rotation scaled by the row's
// scale, floored and saturated to Q16.16, row 3 is the translation.
// The fixed last column is not sent.
//
// Four register stages: products, terms, scale multiply, saturation.
// A transaction accepted on in_i passes through these registers in that
// order before it is offered on out_o. One transaction can be accepted
// every cycle while out_o is not stalled; the scale multiply stage, nine
// 34x32 multipliers in parallel, sets the cycle time.
//
// Reset clears the stage valid bits only; the pipeline comes up empty.
// When out_o is stalled, the stages fill behind the held result and
// in_i.ready drops only once all four stages hold a transaction; bubbles
// are squeezed out while stalled. Nothing is lost or repeated.
module trs_affine_compose_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  trs_stream_if.sink   in_i,
  trs_stream_if.source out_o
);
  import trs_pkg::*;

  logic      v1, v2, v3, r1, r2, r3;
  trs_prod_t d1;
  trs_term_t d2;
  trs_mul_t  d3;
  trs_in_t   in_data;
  trs_out_t  out_data;

  assign in_data = in_i.data;

  trs_prod_stage u_prod (
    .clk_i, .rst_ni,
    .valid_i (in_i.valid), .data_i (in_data), .ready_o (in_i.ready),
    .valid_o (v1), .data_o (d1), .ready_i (r1)
  );

  trs_term_stage u_term (
    .clk_i, .rst_ni,
    .valid_i (v1), .data_i (d1), .ready_o (r1),
    .valid_o (v2), .data_o (d2), .ready_i (r2)
  );

  trs_mul_stage u_mul (
    .clk_i, .rst_ni,
    .valid_i (v2), .data_i (d2), .ready_o (r2),
    .valid_o (v3), .data_o (d3), .ready_i (r3)
  );

  trs_sat_stage u_sat (
    .clk_i, .rst_ni,
    .valid_i (v3), .data_i (d3), .ready_o (r3),
    .valid_o (out_o.valid), .data_o (out_data), .ready_i (out_o.ready)
  );

  assign out_o.data = out_data;
endmodule

>>> hw/rtl/trs_check.sv
// port-level checks for the transform pipeline, bound to the top level
module trs_check (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input trs_pkg::trs_out_t out_data_i
);
  import trs_pkg::*;

  localparam int unsigned Depth = 4;

  logic [2:0] occ_q, occ_d;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // transactions accepted but not yet delivered
  always_comb begin
    occ_d = occ_q;
    if (in_fire && !out_fire) begin
      occ_d = occ_q + 3'd1;
    end else if (!in_fire && out_fire) begin
      occ_d = occ_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // after reset is sampled low the output must be idle
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != 3'd0 && occ_q <= 3'(Depth))
    else $error("result without a matching transaction in flight");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> occ_q == 3'(Depth) && out_valid_i && !out_ready_i)
    else $error("input stalled while pipeline has room");
endmodule

bind trs_affine_compose_unit trs_check u_trs_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
